@@ hdl/fss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fss_pkg
// Types and constants shared by the FASTA stream splitter modules.
// ----------------------------------------------------------------------------
package fss_pkg;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_GT  = 8'h3E;
    localparam logic [7:0] CH_DOT = 8'h2E;

    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned PLEN_W     = 4;

    localparam logic [31:0] RST_MAX_SEQ_LEN = 32'd100000000;
    localparam logic [15:0] RST_MAX_ENTRIES = 16'd100;

    typedef enum logic [1:0] {
        CFG_MAX_SEQ_LEN  = 2'd0,
        CFG_MAX_ENTRIES  = 2'd1,
        CFG_PREFIX_CHARS = 2'd2,
        CFG_PREFIX_LEN   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0]       max_seq_len;
        logic [15:0]       max_entries;
        logic [PLEN_W-1:0] prefix_len;
    } t_cfg;

    // One accepted, non-dropped beat and the burst it expands into
    typedef struct packed {
        logic [7:0]        head_byte;
        logic              new_file;
        logic [15:0]       file_number;
        logic [PLEN_W-1:0] plen;
    } t_item;

endpackage

@@ hdl/fss_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fss_in_if
// Input channel: one raw FASTA byte per beat.
// ----------------------------------------------------------------------------
interface fss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       file_start;

    modport source (output valid, output in_byte, output file_start, input ready);
    modport sink   (input valid, input in_byte, input file_start, output ready);
endinterface

@@ hdl/fss_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fss_out_if
// Output channel: one output byte per beat with file bookkeeping.
// ----------------------------------------------------------------------------
interface fss_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        new_file;
    logic [15:0] file_number;
    logic        last;

    modport source (output valid, output out_byte, output new_file,
                    output file_number, output last, input ready);
    modport sink   (input valid, input out_byte, input new_file,
                    input file_number, input last, output ready);
endinterface

@@ hdl/fasta_stream_splitter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fasta_stream_splitter_unit
// FASTA byte filter and output file splitter with header prefixing.
// ----------------------------------------------------------------------------
// First result beat is valid in the cycle after the input beat is taken.
// Throughput: one input beat per cycle; a stalled output holds the input. A
// header start with a non-empty prefix sends 2 + prefix length beats and holds
// the input until its last beat is taken; an empty prefix sends '>' alone.
// Dropped bytes produce no beat.
// Reset (synchronous, active low) clears counters and header state, sets the
// file number to 1 and restores the register defaults.
// ----------------------------------------------------------------------------
module fasta_stream_splitter_unit
    import fss_pkg::*;
#(
    parameter int unsigned PREFIX_BYTES = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    fss_in_if.sink                i_in_ch,
    fss_out_if.source             o_out_ch
);

    t_cfg                         cfg;
    logic [PREFIX_BYTES-1:0][7:0] prefix;
    logic                         accept;
    logic                         load;
    logic                         free;
    t_item                        item;

    assign i_in_ch.ready = free;
    assign accept        = i_in_ch.valid && free;

    fss_cfg #(.PREFIX_BYTES(PREFIX_BYTES)) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg),
        .o_prefix   (prefix)
    );

    fss_ctrl #(.PREFIX_BYTES(PREFIX_BYTES)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_byte       (i_in_ch.in_byte),
        .i_file_start (i_in_ch.file_start),
        .i_cfg        (cfg),
        .i_prefix     (prefix),
        .o_load       (load),
        .o_item       (item)
    );

    fss_burst #(.PREFIX_BYTES(PREFIX_BYTES)) u_burst (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_item   (item),
        .i_prefix (prefix),
        .o_free   (free),
        .o_out    (o_out_ch)
    );

endmodule

@@ hdl/fss_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fss_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module fss_cfg
    import fss_pkg::*;
#(
    parameter int unsigned PREFIX_BYTES = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  t_cfg_idx                            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]               i_cfg_data,
    output t_cfg                                o_cfg,
    output logic [PREFIX_BYTES-1:0][7:0]        o_prefix
);

    t_cfg                         r_cfg;
    logic [PREFIX_BYTES-1:0][7:0] r_prefix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_seq_len <= RST_MAX_SEQ_LEN;
            r_cfg.max_entries <= RST_MAX_ENTRIES;
            r_cfg.prefix_len  <= '0;
            r_prefix          <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_SEQ_LEN:  r_cfg.max_seq_len <= i_cfg_data[31:0];
                CFG_MAX_ENTRIES:  r_cfg.max_entries <= i_cfg_data[15:0];
                CFG_PREFIX_CHARS: r_prefix          <= i_cfg_data[PREFIX_BYTES*8-1:0];
                CFG_PREFIX_LEN:   r_cfg.prefix_len  <= i_cfg_data[PLEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg    = r_cfg;
    assign o_prefix = r_prefix;

endmodule

@@ hdl/fss_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fss_ctrl
// Byte classification, header/counter state and split decision per beat.
// ----------------------------------------------------------------------------
module fss_ctrl
    import fss_pkg::*;
#(
    parameter int unsigned PREFIX_BYTES = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [7:0]                   i_byte,
    input  logic                         i_file_start,
    input  t_cfg                         i_cfg,
    input  logic [PREFIX_BYTES-1:0][7:0] i_prefix,
    output logic                         o_load,
    output t_item                        o_item
);

    logic        r_in_header;
    logic [31:0] r_seq_count;
    logic [15:0] r_entry_count;
    logic [15:0] r_file_number;

    logic        n_in_header;
    logic [31:0] n_seq_count;
    logic [15:0] n_entry_count;
    logic [15:0] n_file_number;

    logic              hdr;
    logic              split;
    logic              emit;
    logic [PLEN_W-1:0] len_clamp;
    logic [PLEN_W-1:0] plen;
    logic              run;

    // effective prefix length: clamped, cut at the first zero byte
    always_comb begin
        len_clamp = (i_cfg.prefix_len > PLEN_W'(PREFIX_BYTES)) ?
                    PLEN_W'(PREFIX_BYTES) : i_cfg.prefix_len;
        plen = '0;
        run  = 1'b1;
        for (int k = 0; k < PREFIX_BYTES; k++) begin
            if (run && (PLEN_W'(k) < len_clamp) && (i_prefix[k] != CH_NUL)) begin
                plen = PLEN_W'(k + 1);
            end else begin
                run = 1'b0;
            end
        end
    end

    always_comb begin
        hdr           = i_file_start ? 1'b0 : r_in_header;
        split         = (r_entry_count >= i_cfg.max_entries) ||
                        (r_seq_count >= i_cfg.max_seq_len);
        n_in_header   = hdr;
        n_seq_count   = r_seq_count;
        n_entry_count = r_entry_count;
        n_file_number = r_file_number;
        emit          = 1'b0;
        o_item.head_byte   = i_byte;
        o_item.new_file    = 1'b0;
        o_item.plen        = '0;
        if (i_byte == CH_NUL || i_byte == CH_CR) begin
            emit = 1'b0;
        end else if (i_byte == CH_LF) begin
            n_in_header = 1'b0;
            emit        = 1'b1;
        end else if (i_byte == CH_GT && !hdr) begin
            n_in_header = 1'b1;
            emit        = 1'b1;
            o_item.new_file = split;
            o_item.plen     = plen;
            if (split) begin
                if (r_file_number != '1) begin
                    n_file_number = r_file_number + 16'd1;
                end
                n_seq_count   = '0;
                n_entry_count = 16'd1;
            end else if (r_entry_count != '1) begin
                n_entry_count = r_entry_count + 16'd1;
            end
        end else if (hdr) begin
            emit = 1'b1;
        end else if (i_byte == CH_SP || i_byte == CH_TAB ||
                     i_byte == CH_VT || i_byte == CH_FF) begin
            emit = 1'b0;
        end else begin
            emit = 1'b1;
            if (r_seq_count != '1) begin
                n_seq_count = r_seq_count + 32'd1;
            end
        end
        o_item.file_number = n_file_number;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_header   <= 1'b0;
            r_seq_count   <= '0;
            r_entry_count <= '0;
            r_file_number <= 16'd1;
        end else if (i_accept) begin
            r_in_header   <= n_in_header;
            r_seq_count   <= n_seq_count;
            r_entry_count <= n_entry_count;
            r_file_number <= n_file_number;
        end
    end

    assign o_load = i_accept && emit;

endmodule

@@ hdl/fss_burst.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fss_burst
// Result register; expands a header start with a non-empty prefix into '>', prefix and '.'.
// ----------------------------------------------------------------------------
module fss_burst
    import fss_pkg::*;
#(
    parameter int unsigned PREFIX_BYTES = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  t_item                        i_item,
    input  logic [PREFIX_BYTES-1:0][7:0] i_prefix,
    output logic                         o_free,
    fss_out_if.source                    o_out
);

    logic              r_busy;
    t_item             r_item;
    logic [PLEN_W-1:0] r_idx;

    logic [PLEN_W-1:0] last_idx;
    logic              is_last;
    logic              done;
    logic [7:0]        sel_byte;

    always_comb begin
        last_idx = (r_item.plen == '0) ? '0 : r_item.plen + PLEN_W'(1);
        is_last  = (r_idx == last_idx);
        done     = r_busy && o_out.ready && is_last;
        sel_byte = CH_DOT;
        if (r_idx == '0) begin
            sel_byte = r_item.head_byte;
        end else begin
            for (int k = 0; k < PREFIX_BYTES; k++) begin
                if (r_idx == PLEN_W'(k + 1) && r_idx <= r_item.plen) begin
                    sel_byte = i_prefix[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (r_busy && o_out.ready) begin
            r_idx  <= r_idx + PLEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_free            = !r_busy || done;
    assign o_out.valid       = r_busy;
    assign o_out.out_byte    = sel_byte;
    assign o_out.new_file    = r_item.new_file && (r_idx == '0);
    assign o_out.file_number = r_item.file_number;
    assign o_out.last        = is_last;

endmodule
